// ===== hdl/pgvad_pkg.sv =====
// Shared types and constants for the peak-gated voice activity detector.
`default_nettype none
package pgvad_pkg;

  localparam int DEF_MAX_CHUNK  = 4096;
  localparam int DEF_TIME_WIDTH = 32;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int MS_W       = 16;
  localparam int SPM_W      = 9;
  localparam int START_W    = 33;
  localparam int END_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 120;

  localparam logic [LEVEL_W-1:0] CLIP_LEVEL = 16'd32767;

  localparam logic             RST_VAD_ENABLE     = 1'b1;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_THRESHOLD = 16'd2000;
  localparam logic [MS_W-1:0]  RST_HEAD_MARGIN_MS = 16'd300;
  localparam logic [MS_W-1:0]  RST_TAIL_MARGIN_MS = 16'd300;
  localparam logic [MS_W-1:0]  RST_MIN_SAMPLE_MS  = 16'd500;
  localparam logic [SPM_W-1:0] RST_SAMPLES_PER_MS = 9'd16;

  localparam logic [CFG_IDX_W-1:0] REG_VAD_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_MARGIN_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_MARGIN_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLE_MS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_MS  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_MS,
    ST_MS_WAIT,
    ST_TIME,
    ST_ELAPSE,
    ST_DECIDE
  } seq_state_t;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage : pgvad_pkg
`default_nettype wire

// ===== hdl/pgvad_acc.sv =====
// Chunk accumulator: absolute peak, sum of magnitudes and sample count.
`default_nettype none
module pgvad_acc
  import pgvad_pkg::*;
#(
  parameter int MAX_CHUNK = DEF_MAX_CHUNK,
  parameter int CNT_W     = $clog2(MAX_CHUNK + 1),
  parameter int SUM_W     = 15 + CNT_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire acc_ctl_t                   ctl,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic [LEVEL_W-1:0]              peak,
  output logic [SUM_W-1:0]                sum,
  output logic [CNT_W-1:0]                count
);

  logic [LEVEL_W-1:0] mag;

  assign mag = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      peak  <= '0;
      sum   <= '0;
      count <= '0;
    end else if (ctl.add && (count < CNT_W'(MAX_CHUNK))) begin
      if (mag > peak) begin
        peak <= mag;
      end
      sum   <= sum + SUM_W'(mag);
      count <= count + 1'b1;
    end
  end

endmodule : pgvad_acc
`default_nettype wire

// ===== hdl/pgvad_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module pgvad_div
  import pgvad_pkg::*;
#(
  parameter int DIVD_W = 28,
  parameter int DIVS_W = 13
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic [DIVD_W-1:0]      quotient,
  output div_stat_t              stat
);

  localparam int ITER_W = $clog2(DIVD_W + 1);

  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [ITER_W-1:0] iter;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  assign trial = {rem, quotient[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      iter <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        iter      <= ITER_W'(DIVD_W);
      end else if (stat.busy) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (stat.busy) begin
      quotient <= {quotient[DIVD_W-2:0], ge};
      rem      <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end
  end

endmodule : pgvad_div
`default_nettype wire

// ===== hdl/peak_gated_voice_activity_detector.sv =====
// Top level of the peak-gated voice activity detector with hangover.
//
// Audio samples enter on the s_ stream, one signed 16-bit sample per item,
// with s_tlast on the final sample of a chunk. Each sample that does not end
// a chunk is taken while the block is idle. The sample that ends a chunk
// starts a sequence that runs the shared divider twice (mean level, then
// chunk length in milliseconds) and then updates the detection state;
// s_tready is low during it. The divider gives one quotient bit per cycle.
// The result sits in an output register. While it waits, samples of the next
// chunk are still taken, and so is the sample that closes it; that chunk's
// sequence then holds before its decision step, with s_tready low, until the
// waiting result has gone.
// Reset clears the accumulators, the clock and the detection state, and loads
// the default register values. The user must write registers through cfg_we,
// cfg_index and cfg_data only while the block is idle; it does not enforce this.
`default_nettype none
module peak_gated_voice_activity_detector
  import pgvad_pkg::*;
#(
  parameter int MAX_CHUNK  = DEF_MAX_CHUNK,
  parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [15:0] sample
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [15:0] chunk_peak, [31:16] chunk_mean, [32] clipping, [33] pass_through,
  // [34] trim_to_head, [35] listening_start, [36] utterance_done,
  // [69:37] utterance_start_ms, [101:70] utterance_end_ms,
  // [117:102] overall_peak, [119:118] zero
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int CNT_W   = $clog2(MAX_CHUNK + 1);
  localparam int SUM_W   = 15 + CNT_W;
  localparam int DIVS_W  = (CNT_W > SPM_W) ? CNT_W : SPM_W;
  localparam int CALC_W  = (TIME_WIDTH > START_W) ? TIME_WIDTH : START_W;

  // Configuration registers.
  logic               vad_enable;
  logic [LEVEL_W-1:0] level_threshold;
  logic [MS_W-1:0]    head_margin_ms;
  logic [MS_W-1:0]    tail_margin_ms;
  logic [MS_W-1:0]    min_sample_ms;
  logic [SPM_W-1:0]   samples_per_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      vad_enable      <= RST_VAD_ENABLE;
      level_threshold <= RST_LEVEL_THRESHOLD;
      head_margin_ms  <= RST_HEAD_MARGIN_MS;
      tail_margin_ms  <= RST_TAIL_MARGIN_MS;
      min_sample_ms   <= RST_MIN_SAMPLE_MS;
      samples_per_ms  <= RST_SAMPLES_PER_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VAD_ENABLE:      vad_enable      <= cfg_data[0];
        REG_LEVEL_THRESHOLD: level_threshold <= cfg_data[LEVEL_W-1:0];
        REG_HEAD_MARGIN_MS:  head_margin_ms  <= cfg_data[MS_W-1:0];
        REG_TAIL_MARGIN_MS:  tail_margin_ms  <= cfg_data[MS_W-1:0];
        REG_MIN_SAMPLE_MS:   min_sample_ms   <= cfg_data[MS_W-1:0];
        REG_SAMPLES_PER_MS:  samples_per_ms  <= cfg_data[SPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  seq_state_t state;
  seq_state_t state_next;
  acc_ctl_t   acc_ctl;
  div_stat_t  div_stat;
  logic       div_start;
  logic       out_free;
  logic       dec_fire;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    div_start     = 1'b0;
    dec_fire      = 1'b0;
    acc_ctl.add   = 1'b0;
    acc_ctl.clear = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        acc_ctl.add = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: begin
        div_start  = 1'b1;
        state_next = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_MS;
        end
      end
      ST_MS: begin
        div_start  = 1'b1;
        state_next = ST_MS_WAIT;
      end
      ST_MS_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_TIME;
        end
      end
      ST_TIME: begin
        state_next = ST_ELAPSE;
      end
      ST_ELAPSE: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          dec_fire      = 1'b1;
          acc_ctl.clear = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Accumulator and shared divider.
  logic [LEVEL_W-1:0] acc_peak;
  logic [SUM_W-1:0]   acc_sum;
  logic [CNT_W-1:0]   acc_count;
  logic [SUM_W-1:0]   div_dividend;
  logic [DIVS_W-1:0]  div_divisor;
  logic [SUM_W-1:0]   div_quotient;
  logic [SPM_W-1:0]   spm_eff;

  pgvad_acc #(
    .MAX_CHUNK (MAX_CHUNK),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_acc (
    .clk    (clk),
    .rst    (rst),
    .ctl    (acc_ctl),
    .sample (s_tdata[SAMPLE_W-1:0]),
    .peak   (acc_peak),
    .sum    (acc_sum),
    .count  (acc_count)
  );

  assign spm_eff = (samples_per_ms == '0) ? SPM_W'(1) : samples_per_ms;

  always_comb begin
    if (state == ST_MS) begin
      div_dividend = SUM_W'(acc_count);
      div_divisor  = DIVS_W'(spm_eff);
    end else begin
      div_dividend = acc_sum;
      div_divisor  = DIVS_W'(acc_count);
    end
  end

  pgvad_div #(
    .DIVD_W (SUM_W),
    .DIVS_W (DIVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // Chunk figures.
  logic [LEVEL_W-1:0]    mean;
  logic [CNT_W-1:0]      this_ms;
  logic [TIME_WIDTH-1:0] now_end;
  logic                  over_min;
  logic                  silent;

  always_ff @(posedge clk) begin
    if (state == ST_MEAN_WAIT && div_stat.done) begin
      mean <= (acc_count == '0) ? '0 : div_quotient[LEVEL_W-1:0];
    end
    if (state == ST_MS_WAIT && div_stat.done) begin
      this_ms <= div_quotient[CNT_W-1:0];
    end
  end

  // Detection state.
  logic                   wait_start;
  logic                   wait_finish;
  logic                   wait_init;
  logic                   recording;
  logic [TIME_WIDTH-1:0]  now_ms;
  logic [TIME_WIDTH-1:0]  time_last_under;
  logic [TIME_WIDTH-1:0]  time_last_over;
  logic [START_W-1:0]     start_time_ms;
  logic [LEVEL_W-1:0]     previous_peak;
  logic [LEVEL_W-1:0]     peak_max;

  always_ff @(posedge clk) begin
    if (state == ST_TIME) begin
      now_end <= now_ms + TIME_WIDTH'(this_ms);
    end
    if (state == ST_ELAPSE) begin
      over_min <= (now_end - time_last_under) > TIME_WIDTH'(min_sample_ms);
      silent   <= (now_end - time_last_over) > TIME_WIDTH'(tail_margin_ms);
    end
  end

  logic                  wait_start_next;
  logic                  wait_finish_next;
  logic                  wait_init_next;
  logic                  recording_next;
  logic [START_W-1:0]    start_time_ms_next;
  logic [TIME_WIDTH-1:0] time_last_under_next;
  logic [TIME_WIDTH-1:0] time_last_over_next;
  logic [CALC_W-1:0]     start_calc;
  logic                  ev_pass;
  logic                  ev_trim;
  logic                  ev_listen;
  logic                  ev_done;
  logic                  loud;
  logic                  prev_loud;

  assign loud       = acc_peak > level_threshold;
  assign prev_loud  = previous_peak > level_threshold;
  assign start_calc = CALC_W'(time_last_under) - CALC_W'(head_margin_ms);

  always_comb begin
    wait_start_next      = wait_start;
    wait_finish_next     = wait_finish;
    wait_init_next       = wait_init;
    recording_next       = recording;
    start_time_ms_next   = start_time_ms;
    time_last_under_next = time_last_under;
    time_last_over_next  = time_last_over;
    ev_pass              = 1'b0;
    ev_trim              = 1'b0;
    ev_listen            = 1'b0;
    ev_done              = 1'b0;
    if (vad_enable) begin
      if (loud) begin
        if (prev_loud) begin
          if (wait_start) begin
            if (over_min) begin
              wait_start_next  = 1'b0;
              wait_finish_next = 1'b1;
              if (!recording) begin
                ev_listen      = 1'b1;
                ev_pass        = 1'b1;
                recording_next = 1'b1;
              end
            end
          end else begin
            ev_pass = 1'b1;
          end
        end else begin
          if (wait_init) begin
            start_time_ms_next = start_calc[START_W-1:0];
            wait_init_next     = 1'b0;
          end
          if (wait_finish) begin
            ev_pass = 1'b1;
          end
        end
        time_last_over_next = now_end;
      end else begin
        if (wait_finish) begin
          ev_pass = 1'b1;
          if (silent) begin
            recording_next   = 1'b0;
            wait_finish_next = 1'b0;
            wait_start_next  = 1'b1;
            wait_init_next   = 1'b1;
            ev_done          = 1'b1;
          end
        end else if (wait_init) begin
          ev_trim = 1'b1;
        end else if (wait_start) begin
          if (silent) begin
            wait_init_next = 1'b1;
            ev_trim        = 1'b1;
          end
        end
        time_last_under_next = now_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_start      <= 1'b1;
      wait_finish     <= 1'b0;
      wait_init       <= 1'b1;
      recording       <= 1'b0;
      now_ms          <= '0;
      time_last_under <= '0;
      time_last_over  <= '0;
      start_time_ms   <= '0;
      previous_peak   <= '0;
      peak_max        <= '0;
    end else if (dec_fire) begin
      if (acc_peak > peak_max) begin
        peak_max <= acc_peak;
      end
      if (vad_enable) begin
        wait_start      <= wait_start_next;
        wait_finish     <= wait_finish_next;
        wait_init       <= wait_init_next;
        recording       <= recording_next;
        start_time_ms   <= start_time_ms_next;
        time_last_under <= time_last_under_next;
        time_last_over  <= time_last_over_next;
        previous_peak   <= acc_peak;
        now_ms          <= now_end;
      end
    end
  end

  // Output register.
  logic [LEVEL_W-1:0] out_peak;
  logic [LEVEL_W-1:0] out_mean;
  logic               out_clip;
  logic               out_pass;
  logic               out_trim;
  logic               out_listen;
  logic               out_done;
  logic [START_W-1:0] out_start;
  logic [END_W-1:0]   out_end;
  logic [LEVEL_W-1:0] out_overall;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dec_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_fire) begin
      out_peak    <= acc_peak;
      out_mean    <= mean;
      out_clip    <= acc_peak >= CLIP_LEVEL;
      out_pass    <= ev_pass;
      out_trim    <= ev_trim;
      out_listen  <= ev_listen;
      out_done    <= ev_done;
      out_start   <= ev_done ? start_time_ms : '0;
      out_end     <= END_W'(now_end);
      out_overall <= (acc_peak > peak_max) ? acc_peak : peak_max;
    end
  end

  assign m_tdata = {2'b00, out_overall, out_end, out_start, out_done, out_listen,
                    out_trim, out_pass, out_clip, out_mean, out_peak};

  // The start and finish waits alternate and never overlap.
  a_wait_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot({wait_start, wait_finish}))
    else $error("start and finish waits not exclusive");

  // An utterance is being recorded exactly while its end is awaited.
  a_rec_finish: assert property (@(posedge clk) disable iff (rst)
    recording |-> wait_finish)
    else $error("recording without finish wait");

  // One chunk cannot both confirm a start and finish an utterance.
  a_listen_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_listen && out_done))
    else $error("start and finish in one chunk");

  // Trimming only happens outside an utterance, where audio is never passed.
  a_pass_trim: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_pass && out_trim))
    else $error("pass-through and trim together");

  // The divider is started only when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule : peak_gated_voice_activity_detector
`default_nettype wire
